// ----- sv/symbol_class_range_splitter_unit_defines.svh -----
// assertion macros for the symbol class range splitter
`ifndef SYMBOL_CLASS_RANGE_SPLITTER_UNIT_DEFINES_SVH
`define SYMBOL_CLASS_RANGE_SPLITTER_UNIT_DEFINES_SVH

// clocked check, held off while reset is asserted
`define SCRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen outside reset
`define SCRS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- sv/scrs_pkg.sv -----
`timescale 1ns / 1ps

package scrs_pkg;

    localparam int POSITION_BITS = 16;
    localparam int SYMBOL_BITS   = 8;
    localparam int CLASS_BITS    = 7;
    localparam int RUN_BITS      = 8;
    localparam int FIELD_BITS    = 16;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int TDATA_BITS    = 40;

    localparam logic [SYMBOL_BITS-1:0]   MAX_SYMBOL = 8'd64;
    localparam logic [RUN_BITS-1:0]      NO_CLASS   = 8'hFF;
    localparam logic [POSITION_BITS-1:0] POS_LIMIT  = '1;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPLIT_CLASS = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPLIT_LIMIT = 1'd1;

    // class bits
    localparam logic [CLASS_BITS-1:0] CLS_B0 = 7'(1 << 0);
    localparam logic [CLASS_BITS-1:0] CLS_B1 = 7'(1 << 1);
    localparam logic [CLASS_BITS-1:0] CLS_B2 = 7'(1 << 2);
    localparam logic [CLASS_BITS-1:0] CLS_B3 = 7'(1 << 3);
    localparam logic [CLASS_BITS-1:0] CLS_B4 = 7'(1 << 4);
    localparam logic [CLASS_BITS-1:0] CLS_B5 = 7'(1 << 5);
    localparam logic [CLASS_BITS-1:0] CLS_B6 = 7'(1 << 6);

    typedef struct packed {
        logic [FIELD_BITS-1:0] start_pos;
        logic [FIELD_BITS-1:0] range_end;
        logic [CLASS_BITS-1:0] range_class;
        logic                  sequence_done;
        logic                  error;
    } result_t;

    function automatic logic [CLASS_BITS-1:0] class_of(input logic [SYMBOL_BITS-1:0] sym);
        logic [CLASS_BITS-1:0] cls;
        if (sym <= 8'd5) begin
            cls = CLS_B0 | CLS_B2 | CLS_B4 | CLS_B5;
        end else if (sym <= 8'd25) begin
            cls = CLS_B0 | CLS_B2 | CLS_B5;
        end else if (sym <= 8'd31) begin
            cls = CLS_B1 | CLS_B2 | CLS_B4 | CLS_B5;
        end else if (sym <= 8'd51) begin
            cls = CLS_B1 | CLS_B2 | CLS_B5;
        end else if (sym <= 8'd61) begin
            cls = CLS_B0 | CLS_B1 | CLS_B3 | CLS_B4 | CLS_B5;
        end else begin
            cls = CLS_B6;
        end
        return cls;
    endfunction

endpackage

// ----- sv/symbol_class_range_splitter_unit.sv -----
`timescale 1ns / 1ps
// channel | ports                                     | payload
// --------+-------------------------------------------+-------------------------------------
// input   | s_tvalid s_tready s_tdata s_tlast         | symbol in tdata, last_symbol on tlast
// result  | m_tvalid m_tready m_tdata m_tlast m_tuser | range in tdata, done/error on tlast/tuser
// config  | cfg_we cfg_addr cfg_wdata                 | split_class (0), split_limit (1)
//
// one symbol is taken per cycle while s_tready is high; classification and range
// update is a single step, its results are written to a four-entry result queue
// at the accepting edge and offered from the next cycle
// a symbol can give up to two results, sent one per cycle while m_tready is high;
// s_tready drops while fewer than two queue slots are free
// reset is synchronous and active low; no clearing pass is needed
`include "symbol_class_range_splitter_unit_defines.svh"

module symbol_class_range_splitter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [scrs_pkg::SYMBOL_BITS-1:0]     s_tdata,   // [7:0] symbol
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [scrs_pkg::TDATA_BITS-1:0]      m_tdata,   // [15:0] start_pos, [31:16]
                                                            // range_end, [38:32] range_class
    output logic                                 m_tlast,
    output logic                                 m_tuser,   // [0] error
    input  logic                                 cfg_we,
    input  logic [scrs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [scrs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import scrs_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = PTR_BITS + 1;

    logic [RUN_BITS-1:0]      split_class_reg;
    logic [FIELD_BITS-1:0]    split_limit_reg;

    logic [RUN_BITS-1:0]      rc_reg, rc_next;
    logic [POSITION_BITS-1:0] origin_reg, origin_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     split_on_reg, split_on_next;
    logic [FIELD_BITS-1:0]    left_reg, left_next;
    logic [RUN_BITS-1:0]      act_reg, act_next;
    logic                     stopped_reg, stopped_next;
    logic                     failed_reg, failed_next;
    logic                     at_start_reg;

    // state as seen by the incoming symbol, reloaded at a sequence start
    logic [RUN_BITS-1:0]      e_rc, e_act;
    logic [POSITION_BITS-1:0] e_origin, e_pos;
    logic                     e_split_on, e_stopped, e_failed;
    logic [FIELD_BITS-1:0]    e_left;

    logic [CLASS_BITS-1:0]    cls;
    logic [RUN_BITS-1:0]      anded;
    logic                     s_xfer, m_xfer;
    logic                     v0, v1;
    result_t                  res0, res1, first_res;

    result_t                  fifo_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [CNT_BITS-1:0]      n_wr;
    result_t                  head;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_comb begin
        if (at_start_reg) begin
            e_rc       = NO_CLASS;
            e_origin   = '0;
            e_pos      = '0;
            e_split_on = 1'b0;
            e_left     = split_limit_reg;
            e_act      = split_class_reg;
            e_stopped  = 1'b0;
            e_failed   = 1'b0;
        end else begin
            e_rc       = rc_reg;
            e_origin   = origin_reg;
            e_pos      = pos_reg;
            e_split_on = split_on_reg;
            e_left     = left_reg;
            e_act      = act_reg;
            e_stopped  = stopped_reg;
            e_failed   = failed_reg;
        end
    end

    assign cls   = class_of(s_tdata);
    assign anded = e_rc & {1'b0, cls};

    always_comb begin
        rc_next       = e_rc;
        origin_next   = e_origin;
        pos_next      = e_pos;
        split_on_next = e_split_on;
        left_next     = e_left;
        act_next      = e_act;
        stopped_next  = e_stopped;
        failed_next   = e_failed;
        v0            = 1'b0;
        v1            = 1'b0;
        res0          = '0;
        res1          = '0;
        if (!e_failed) begin
            if (e_pos >= POS_LIMIT || (!e_stopped && s_tdata > MAX_SYMBOL)) begin
                failed_next        = 1'b1;
                v0                 = 1'b1;
                res0.sequence_done = 1'b1;
                res0.error         = 1'b1;
            end else begin
                if (!e_stopped && anded != e_rc) begin
                    rc_next = anded;
                    if ({1'b0, cls} == e_act) begin
                        origin_next   = e_pos;
                        rc_next       = {1'b0, cls};
                        split_on_next = 1'b1;
                        if (e_left != '0) begin
                            left_next = e_left - 1'b1;
                            if (e_left == FIELD_BITS'(1)) begin
                                act_next = NO_CLASS;
                            end
                        end
                    end else if (e_split_on) begin
                        origin_next   = e_pos;
                        rc_next       = {1'b0, cls};
                        split_on_next = 1'b0;
                    end
                    if (e_rc != NO_CLASS) begin
                        v0               = 1'b1;
                        res0.start_pos   = FIELD_BITS'(e_origin);
                        res0.range_end   = FIELD_BITS'(e_pos);
                        res0.range_class = e_rc[CLASS_BITS-1:0];
                        // an all-zero class ends examination for this sequence
                        if (rc_next == '0) begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                pos_next = e_pos + 1'b1;
                if (s_tlast) begin
                    v1                 = 1'b1;
                    res1.start_pos     = FIELD_BITS'(origin_next);
                    res1.range_end     = FIELD_BITS'(pos_next);
                    res1.range_class   = rc_next[CLASS_BITS-1:0];
                    res1.sequence_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_class_reg <= NO_CLASS;
            split_limit_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SPLIT_CLASS: split_class_reg <= cfg_wdata[RUN_BITS-1:0];
                REG_SPLIT_LIMIT: split_limit_reg <= cfg_wdata[FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg       <= NO_CLASS;
            origin_reg   <= '0;
            pos_reg      <= '0;
            split_on_reg <= 1'b0;
            left_reg     <= '0;
            act_reg      <= NO_CLASS;
            stopped_reg  <= 1'b0;
            failed_reg   <= 1'b0;
            at_start_reg <= 1'b1;
        end else if (s_xfer) begin
            rc_reg       <= rc_next;
            origin_reg   <= origin_next;
            pos_reg      <= pos_next;
            split_on_reg <= split_on_next;
            left_reg     <= left_next;
            act_reg      <= act_next;
            stopped_reg  <= stopped_next;
            failed_reg   <= failed_next;
            at_start_reg <= s_tlast;
        end
    end

    // result queue
    assign n_wr      = s_xfer ? (CNT_BITS'(v0) + CNT_BITS'(v1)) : '0;
    assign first_res = v0 ? res0 : res1;
    assign cnt_next  = cnt_reg + n_wr - CNT_BITS'(m_xfer);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_wr[PTR_BITS-1:0];
            rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(m_xfer);
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_wr != '0) begin
            fifo_reg[wr_ptr_reg] <= first_res;
        end
        if (n_wr == CNT_BITS'(2)) begin
            fifo_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign s_tready = cnt_reg <= CNT_BITS'(FIFO_DEPTH - 2);
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = {1'b0, head.range_class, head.range_end, head.start_pos};
    assign m_tlast  = head.sequence_done;
    assign m_tuser  = head.error;

    `SCRS_ASSERT_NEVER(a_queue_bound, cnt_reg > CNT_BITS'(FIFO_DEPTH), "result queue overrun")
    `SCRS_ASSERT(a_error_zero, m_tvalid && m_tuser |-> m_tdata == '0, "error with range data")
    `SCRS_ASSERT(a_stop_class, stopped_reg && !at_start_reg |-> rc_reg == '0, "stopped on class")
    `SCRS_ASSERT(a_err_done, m_tvalid && m_tuser |-> m_tlast, "error not ending sequence")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import scrs_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE        = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 250;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   last;
    } symbol_item_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [SYMBOL_BITS-1:0]   s_tdata   = '0;
    logic                     s_tlast   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [TDATA_BITS-1:0]    m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    symbol_item_t pending_symbols [$];
    result_t      expected_ranges [$];
    symbol_item_t next_item;

    int unsigned cycle_count          = 0;
    int unsigned mismatch_count       = 0;
    int unsigned send_gap             = 0;
    int unsigned recv_gap             = 0;
    int unsigned hold_left            = 0;
    int unsigned long_holds_requested = 0;
    int unsigned long_holds_served    = 0;
    bit          sender_idles         = 1'b0;
    bit          receiver_idles       = 1'b0;

    // register copies and per-sequence state of the predictor
    logic [7:0]  reg_split_class = NO_CLASS;
    logic [15:0] reg_split_limit = '0;
    logic [7:0]  run_class       = NO_CLASS;
    logic [7:0]  armed_split     = NO_CLASS;
    logic [15:0] origin          = '0;
    logic [15:0] seq_position    = '0;
    logic [15:0] splits_left     = '0;
    logic        split_on        = 1'b0;
    logic        seq_stopped     = 1'b0;
    logic        seq_failed      = 1'b0;
    logic        seq_start_due   = 1'b1;

    symbol_class_range_splitter_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] symbol_class(input logic [7:0] sym);
        if (sym <= 8'd5)  return 8'd53;
        if (sym <= 8'd25) return 8'd37;
        if (sym <= 8'd31) return 8'd54;
        if (sym <= 8'd51) return 8'd38;
        if (sym <= 8'd61) return 8'd59;
        return 8'd64;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] symbol_in_group(input int g);
        case (g)
            0: return 8'($urandom_range(0, 5));
            1: return 8'($urandom_range(6, 25));
            2: return 8'($urandom_range(26, 31));
            3: return 8'($urandom_range(32, 51));
            4: return 8'($urandom_range(52, 61));
            default: return 8'($urandom_range(62, 64));
        endcase
    endfunction

    // class groups picked evenly, with a lean towards the split class and an occasional symbol above MAX_SYMBOL
    function automatic logic [7:0] pick_symbol();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) return 8'($urandom_range(65, 255));
        if (r < 30) begin
            for (int g = 0; g < 6; g++) begin
                if (symbol_class(symbol_in_group(g)) == reg_split_class)
                    return symbol_in_group(g);
            end
        end
        return symbol_in_group($urandom_range(0, 5));
    endfunction

    task automatic push_range(input logic [15:0] first, input logic [15:0] past,
                              input logic [7:0] cls, input logic done, input logic err);
        result_t r;
        r.start_pos     = first;
        r.range_end     = past;
        r.range_class   = cls[CLASS_BITS-1:0];
        r.sequence_done = done;
        r.error         = err;
        expected_ranges.push_back(r);
    endtask

    task automatic predict_ranges(input logic [7:0] sym, input logic last);
        logic [7:0]  cls;
        logic [7:0]  nxt;
        logic [15:0] p;
        logic [15:0] old_origin;
        if (seq_start_due) begin
            run_class     = NO_CLASS;
            origin        = '0;
            seq_position  = '0;
            split_on      = 1'b0;
            splits_left   = reg_split_limit;
            armed_split   = reg_split_class;
            seq_stopped   = 1'b0;
            seq_failed    = 1'b0;
            seq_start_due = 1'b0;
        end
        if (!seq_failed) begin
            if (seq_position == POS_LIMIT) begin
                seq_failed = 1'b1;
                push_range('0, '0, '0, 1'b1, 1'b1);
            end else begin
                p = seq_position;
                if (!seq_stopped) begin
                    if (sym > MAX_SYMBOL) begin
                        seq_failed = 1'b1;
                        push_range('0, '0, '0, 1'b1, 1'b1);
                    end else begin
                        cls = symbol_class(sym);
                        nxt = run_class & cls;
                        if (nxt != run_class) begin
                            old_origin = origin;
                            if (cls == armed_split) begin
                                origin   = p;
                                nxt      = cls;
                                split_on = 1'b1;
                                if (splits_left != 0) begin
                                    splits_left--;
                                    if (splits_left == 0) armed_split = NO_CLASS;
                                end
                            end else if (split_on) begin
                                origin   = p;
                                nxt      = cls;
                                split_on = 1'b0;
                            end
                            // the very first symbol only sets the class
                            if (run_class != NO_CLASS) begin
                                push_range(old_origin, p, run_class, 1'b0, 1'b0);
                                if (nxt == 0) seq_stopped = 1'b1;
                            end
                            run_class = nxt;
                        end
                    end
                end
                if (!seq_failed) begin
                    seq_position = p + 16'd1;
                    if (last) push_range(origin, p + 16'd1, run_class, 1'b1, 1'b0);
                end
            end
        end
        if (last) seq_start_due = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // input side: one transfer per handshake, fed from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_ranges(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_symbols.size() != 0) begin
                    next_item = pending_symbols.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= next_item.symbol;
                    s_tlast   <= next_item.last;
                    send_gap  = sender_idles ? pick_gap() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: compare each transfer with the oldest expected range
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_ranges.size() == 0) begin
                    report_mismatch("result with nothing outstanding", m_tdata[15:0], 0);
                end else begin
                    want = expected_ranges.pop_front();
                    if (m_tdata[15:0] != want.start_pos)
                        report_mismatch("start_pos", m_tdata[15:0], want.start_pos);
                    if (m_tdata[31:16] != want.range_end)
                        report_mismatch("range_end", m_tdata[31:16], want.range_end);
                    if (m_tdata[38:32] != want.range_class)
                        report_mismatch("range_class", m_tdata[38:32], want.range_class);
                    if (m_tlast != want.sequence_done)
                        report_mismatch("sequence_done", m_tlast, want.sequence_done);
                    if (m_tuser != want.error)
                        report_mismatch("error", m_tuser, want.error);
                end
            end
            if (long_holds_served != long_holds_requested) begin
                long_holds_served = long_holds_requested;
                hold_left         = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = receiver_idles ? pick_gap() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_item(input logic [7:0] sym, input logic last);
        symbol_item_t item;
        item.symbol = sym;
        item.last   = last;
        pending_symbols.push_back(item);
    endtask

    task automatic queue_sequences(input int n_items);
        int queued;
        int len;
        int unsigned r;
        bit noisy;
        queued = 0;
        while (queued < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 80) len = $urandom_range(1, 10);
            else if (r < 95) len = $urandom_range(11, 40);
            else len = $urandom_range(41, 120);
            // now and then a sequence of raw bytes
            noisy = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < len; i++)
                queue_item(noisy ? 8'($urandom) : pick_symbol(), i == len - 1);
            queued += len;
        end
    endtask

    task automatic write_register(input logic [CFG_ADDR_BITS-1:0] addr,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        if (addr == REG_SPLIT_CLASS) reg_split_class = data[7:0];
        else reg_split_limit = data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_for_drain();
        do @(negedge aclk);
        while (pending_symbols.size() != 0 || s_tvalid || expected_ranges.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        logic [7:0]  split_value;
        logic [15:0] limit_value;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // class narrows step by step down to zero, then a bad index is skipped
        queue_item(8'd0, 1'b0);
        queue_item(8'd5, 1'b0);
        queue_item(8'd6, 1'b0);
        queue_item(8'd25, 1'b0);
        queue_item(8'd26, 1'b0);
        queue_item(8'd31, 1'b0);
        queue_item(8'd32, 1'b0);
        queue_item(8'd51, 1'b0);
        queue_item(8'd52, 1'b0);
        queue_item(8'd61, 1'b0);
        queue_item(8'd62, 1'b0);
        queue_item(8'd64, 1'b0);
        queue_item(8'd200, 1'b1);
        queue_item(8'd63, 1'b1);
        // bad index mid-sequence, then a bad index that is also last
        queue_item(8'd65, 1'b0);
        queue_item(8'd3, 1'b1);
        queue_item(8'd255, 1'b1);
        wait_for_drain();

        // enter a split, leave it, and two results at the final symbol
        write_register(REG_SPLIT_CLASS, 16'd37);
        write_register(REG_SPLIT_LIMIT, 16'd1);
        queue_item(8'd0, 1'b0);
        queue_item(8'd10, 1'b0);
        queue_item(8'd3, 1'b0);
        queue_item(8'd40, 1'b0);
        queue_item(8'd30, 1'b0);
        queue_item(8'd10, 1'b1);
        wait_for_drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin split_value = 8'd37;  limit_value = 16'd0;      end
                1: begin split_value = 8'd53;  limit_value = 16'd1;      end
                2: begin split_value = 8'd38;  limit_value = 16'd2;      end
                3: begin split_value = 8'd54;  limit_value = 16'hFFFF;   end
                4: begin split_value = 8'd59;  limit_value = 16'($urandom_range(1, 4)); end
                5: begin split_value = 8'd64;  limit_value = 16'd0;      end
                6: begin split_value = NO_CLASS; limit_value = 16'($urandom); end
                default: begin
                    split_value = 8'($urandom);
                    limit_value = 16'd3;
                end
            endcase
            write_register(REG_SPLIT_CLASS, {8'd0, split_value});
            write_register(REG_SPLIT_LIMIT, limit_value);
            sender_idles   = (phase % 3 != 1);
            receiver_idles = (phase % 3 != 2);
            if (phase == 2) begin
                // results back up while input keeps coming
                sender_idles = 1'b0;
                long_holds_requested++;
            end
            queue_sequences(PHASE_ITEMS);
            wait_for_drain();
        end

        if (mismatch_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/scrs_pkg.sv
sv/symbol_class_range_splitter_unit.sv
verif/testbench.sv
